// File: rtl/core/text_command_line_decoder_assert.svh
// Assertion macros shared by the text command line decoder RTL.
// Depends on a signal named clock and a synchronous active-high reset named reset.
`ifndef TEXT_COMMAND_LINE_DECODER_ASSERT_SVH
`define TEXT_COMMAND_LINE_DECODER_ASSERT_SVH

// Condition holds at every edge outside reset.
`define TCLD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TCLD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tcld_pkg.sv
// Package for the text command line decoder: constants, codes and command words.
// No dependencies; used by every module of the block.
package tcld_pkg;

   localparam int LINE_CAPACITY_DEF = 64;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam int NUM_W = 17;
   localparam logic [NUM_W-1:0] NUM_CAP    = 17'd100000;
   localparam logic [NUM_W-1:0] BRIGHT_MAX = 17'd100;
   localparam logic [NUM_W-1:0] BLINK_MAX  = 17'd6553;

   localparam int BRIGHT_W = 7;
   localparam int BLINK_W  = 13;

   localparam logic [0:3][7:0] HELP_WORD   = "help";
   localparam logic [0:2][7:0] PWM_WORD    = "pwm";
   localparam logic [0:4][7:0] BLINK_WORD  = "blink";
   localparam logic [0:5][7:0] STATUS_WORD = "status";

   typedef enum logic {
      KIND_STORE = 1'b0,
      KIND_END   = 1'b1
   } item_kind_type;

   typedef enum logic [2:0] {
      RC_HELP       = 3'd0,
      RC_BRIGHT_SET = 3'd1,
      RC_BLINK_OFF  = 3'd2,
      RC_BLINK_SET  = 3'd3,
      RC_STATUS     = 3'd4,
      RC_BAD_PWM    = 3'd5,
      RC_BAD_BLINK  = 3'd6,
      RC_UNKNOWN    = 3'd7
   } reply_code_type;

endpackage

// File: rtl/core/text_command_line_decoder.sv
// Top level of the text command line decoder: front end, item queue, back end.
// Depends on tcld_pkg, tcld_front, tcld_queue and tcld_back.
//
//   Channel   Dir   Ports                                   Beat
//   req       in    req_valid, req_ready, req_rx_byte       one received byte
//   rsp       out   rsp_valid, rsp_ready, rsp_reply_code,   one decoded line
//                   rsp_brightness_now, rsp_blink_now
//
// The front end takes one byte a cycle while the queue has room; a byte that
// extends a line costs the back end one store, a dropped byte costs nothing.
// A line end makes the back end scan the stored characters through the
// single read port of the line store, one character a cycle, then drain the
// last read and decide the reply.
// The back end holds a line end while a reply still waits on rsp; bytes keep
// flowing into the queue until it fills, then req_ready drops.
// Reset clears line length, drop state, settings and reply valid; the line
// store itself is not cleared and needs no clearing pass.
module text_command_line_decoder #(
   parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_reply_code,
   output logic [tcld_pkg::BRIGHT_W-1:0]     rsp_brightness_now,
   output logic [tcld_pkg::BLINK_W-1:0]      rsp_blink_now
);
   import tcld_pkg::*;

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam int ITEM_W = 1 + 8 + LEN_W;

   logic              in_accept;
   logic              push;
   item_kind_type     push_kind;
   logic [7:0]        push_byte;
   logic [LEN_W-1:0]  push_pos;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   logic [ITEM_W-1:0] q_data;
   item_kind_type     q_kind;

   // accept a byte whenever the queue can take whatever it turns into
   assign req_ready = !q_full;
   assign in_accept = req_valid && req_ready;

   tcld_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_accept(in_accept),
      .in_byte  (req_rx_byte),
      .push     (push),
      .push_kind(push_kind),
      .push_byte(push_byte),
      .push_pos (push_pos)
   );

   // item: kind, byte, then store index or line length
   tcld_queue #(
      .WIDTH(ITEM_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_kind, push_byte, push_pos}),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_data (q_data)
   );

   assign q_kind = item_kind_type'(q_data[ITEM_W-1]);

   tcld_back #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_kind            (q_kind),
      .q_byte            (q_data[LEN_W+7:LEN_W]),
      .q_pos             (q_data[LEN_W-1:0]),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_reply_code    (rsp_reply_code),
      .rsp_brightness_now(rsp_brightness_now),
      .rsp_blink_now     (rsp_blink_now)
   );

endmodule

// File: rtl/core/tcld_front.sv
// Front end: classifies received bytes into store and line-end items.
// Depends on tcld_pkg; tracks line length and the drop state of over-long lines.
module tcld_front #(
   parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_accept,
   input  logic [7:0]                        in_byte,
   output logic                              push,
   output tcld_pkg::item_kind_type           push_kind,
   output logic [7:0]                        push_byte,
   output logic [$clog2(LINE_CAPACITY)-1:0]  push_pos
);
   import tcld_pkg::*;

   localparam int LEN_W = $clog2(LINE_CAPACITY);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             discard_ff, discard_in;
   logic             is_eol;

   assign is_eol = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);

   always_comb begin
      len_in     = len_ff;
      discard_in = discard_ff;
      push       = 1'b0;
      push_kind  = KIND_STORE;
      push_byte  = in_byte;
      push_pos   = len_ff;
      if (in_accept) begin
         if (is_eol) begin
            len_in     = '0;
            discard_in = 1'b0;
            if (!discard_ff && len_ff != '0) begin
               push      = 1'b1;
               push_kind = KIND_END;
            end
         end else if (!discard_ff) begin
            if (len_ff < LEN_W'(LINE_CAPACITY - 1)) begin
               push   = 1'b1;
               len_in = len_ff + 1'b1;
            end else begin
               // drop the rest of an over-long line
               len_in     = '0;
               discard_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         discard_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// File: rtl/core/tcld_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on tcld_pkg for the default depth.
module tcld_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tcld_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import tcld_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/tcld_back.sv
// Back end: line store, character scan, command decode and reply register.
// Depends on tcld_pkg and text_command_line_decoder_assert.svh.
`include "text_command_line_decoder_assert.svh"

module tcld_back #(
   parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  tcld_pkg::item_kind_type           q_kind,
   input  logic [7:0]                        q_byte,
   input  logic [$clog2(LINE_CAPACITY)-1:0]  q_pos,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_reply_code,
   output logic [tcld_pkg::BRIGHT_W-1:0]     rsp_brightness_now,
   output logic [tcld_pkg::BLINK_W-1:0]      rsp_blink_now
);
   import tcld_pkg::*;

   localparam int LEN_W  = $clog2(LINE_CAPACITY);
   localparam int DEPTH  = LINE_CAPACITY - 1;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'b0001,
      PH_DIGITS = 4'b0010,
      PH_TRAIL  = 4'b0100,
      PH_BAD    = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [NUM_W-1:0] val;
   } num_type;

   localparam num_type NUM_INIT = '{phase: PH_LEAD, val: '0};

   // one character of the number syntax: spaces, digits, spaces, end
   function automatic num_type num_step(num_type s, logic [7:0] c);
      num_type          r;
      logic             is_digit;
      logic [3:0]       d;
      logic [NUM_W+3:0] acc;
      r        = s;
      is_digit = c inside {["0":"9"]};
      d        = 4'(c - CHAR_ZERO);
      acc      = {1'b0, s.val, 3'b000} + {3'b000, s.val, 1'b0} + {(NUM_W)'(0), d};
      case (s.phase)
         PH_LEAD: begin
            if (is_digit) begin
               r.phase = PH_DIGITS;
               r.val   = {(NUM_W-4)'(0), d};
            end else if (c != CHAR_SPACE) begin
               r.phase = PH_BAD;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               r.val = (acc > {4'b0000, NUM_CAP}) ? NUM_CAP : acc[NUM_W-1:0];
            end else if (c == CHAR_SPACE) begin
               r.phase = PH_TRAIL;
            end else begin
               r.phase = PH_BAD;
            end
         end
         PH_TRAIL: begin
            if (c != CHAR_SPACE) begin
               r.phase = PH_BAD;
            end
         end
         default: r.phase = PH_BAD;
      endcase
      return r;
   endfunction

   logic [7:0]          line_mem [DEPTH];
   logic [7:0]          rd_data_ff;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                char_vld_ff, char_vld_in;
   logic [LEN_W-1:0]    char_pos_ff, char_pos_in;

   logic                help_ok_ff, help_ok_in;
   logic                pwm_ok_ff, pwm_ok_in;
   logic                blink_ok_ff, blink_ok_in;
   logic                status_ok_ff, status_ok_in;
   num_type             pwm_num_ff, pwm_num_in;
   num_type             blk_num_ff, blk_num_in;

   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic [BLINK_W-1:0]  blink_ff, blink_in;

   logic                rsp_valid_ff, rsp_valid_in;
   reply_code_type      rsp_code_ff, rsp_code_in;
   logic [BRIGHT_W-1:0] rsp_bright_ff;
   logic [BLINK_W-1:0]  rsp_blink_ff;

   logic                pwm_good, blk_good;
   logic                end_pop;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_code     = rsp_code_ff;
   assign rsp_brightness_now = rsp_bright_ff;
   assign rsp_blink_now      = rsp_blink_ff;

   // a line end waits until the previous reply has left
   assign q_pop = (state_ff == S_IDLE) && q_valid && ((q_kind == KIND_STORE) || !rsp_valid_ff);
   assign end_pop = q_pop && (q_kind == KIND_END);

   assign pwm_good = ((pwm_num_ff.phase == PH_DIGITS) || (pwm_num_ff.phase == PH_TRAIL))
                     && (pwm_num_ff.val <= BRIGHT_MAX);
   assign blk_good = ((blk_num_ff.phase == PH_DIGITS) || (blk_num_ff.phase == PH_TRAIL))
                     && (blk_num_ff.val <= BLINK_MAX);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      char_vld_in  = 1'b0;
      char_pos_in  = char_pos_ff;
      help_ok_in   = help_ok_ff;
      pwm_ok_in    = pwm_ok_ff;
      blink_ok_in  = blink_ok_ff;
      status_ok_in = status_ok_ff;
      pwm_num_in   = pwm_num_ff;
      blk_num_in   = blk_num_ff;
      bright_in    = bright_ff;
      blink_in     = blink_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;

      // fold in the character read last cycle
      if (char_vld_ff) begin
         if (char_pos_ff < LEN_W'(4)) begin
            help_ok_in = help_ok_ff && (rd_data_ff == HELP_WORD[char_pos_ff[1:0]]);
         end
         if (char_pos_ff < LEN_W'(3)) begin
            pwm_ok_in = pwm_ok_ff && (rd_data_ff == PWM_WORD[char_pos_ff[1:0]]);
         end else begin
            pwm_num_in = num_step(pwm_num_ff, rd_data_ff);
         end
         if (char_pos_ff < LEN_W'(5)) begin
            blink_ok_in = blink_ok_ff && (rd_data_ff == BLINK_WORD[char_pos_ff[2:0]]);
         end else begin
            blk_num_in = num_step(blk_num_ff, rd_data_ff);
         end
         if (char_pos_ff < LEN_W'(6)) begin
            status_ok_in = status_ok_ff && (rd_data_ff == STATUS_WORD[char_pos_ff[2:0]]);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (end_pop) begin
               state_in     = S_SCAN;
               len_in       = q_pos;
               rd_idx_in    = '0;
               help_ok_in   = 1'b1;
               pwm_ok_in    = 1'b1;
               blink_ok_in  = 1'b1;
               status_ok_in = 1'b1;
               pwm_num_in   = NUM_INIT;
               blk_num_in   = NUM_INIT;
            end
         end
         S_SCAN: begin
            char_vld_in = 1'b1;
            char_pos_in = LEN_W'(rd_idx_ff);
            rd_idx_in   = rd_idx_ff + 1'b1;
            if (LEN_W'(rd_idx_ff) == len_ff - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (help_ok_ff && len_ff >= LEN_W'(4)) begin
               rsp_code_in = RC_HELP;
            end else if (pwm_ok_ff && len_ff >= LEN_W'(3)) begin
               if (pwm_good) begin
                  bright_in   = pwm_num_ff.val[BRIGHT_W-1:0];
                  rsp_code_in = RC_BRIGHT_SET;
               end else begin
                  rsp_code_in = RC_BAD_PWM;
               end
            end else if (blink_ok_ff && len_ff >= LEN_W'(5)) begin
               if (blk_good) begin
                  blink_in    = blk_num_ff.val[BLINK_W-1:0];
                  rsp_code_in = (blk_num_ff.val == '0) ? RC_BLINK_OFF : RC_BLINK_SET;
               end else begin
                  rsp_code_in = RC_BAD_BLINK;
               end
            end else if (status_ok_ff && len_ff >= LEN_W'(6)) begin
               rsp_code_in = RC_STATUS;
            end else begin
               rsp_code_in = RC_UNKNOWN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (q_pop && (q_kind == KIND_STORE)) begin
         line_mem[q_pos[ADDR_W-1:0]] <= q_byte;
      end
      if (state_ff == S_SCAN) begin
         rd_data_ff <= line_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      rd_idx_ff    <= rd_idx_in;
      char_pos_ff  <= char_pos_in;
      help_ok_ff   <= help_ok_in;
      pwm_ok_ff    <= pwm_ok_in;
      blink_ok_ff  <= blink_ok_in;
      status_ok_ff <= status_ok_in;
      pwm_num_ff   <= pwm_num_in;
      blk_num_ff   <= blk_num_in;
      rsp_code_ff  <= rsp_code_in;
      if (state_ff == S_DECIDE) begin
         rsp_bright_ff <= bright_in;
         rsp_blink_ff  <= blink_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         char_vld_ff  <= 1'b0;
         bright_ff    <= '0;
         blink_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         char_vld_ff  <= char_vld_in;
         bright_ff    <= bright_in;
         blink_ff     <= blink_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TCLD_ASSERT_IMPLY(a_char_inside_line, char_vld_ff, char_pos_ff < len_ff, "scan past end")
   `TCLD_ASSERT_IMPLY(a_end_waits_reply, end_pop, !rsp_valid_ff, "line end over pending reply")
   `TCLD_ASSERT_NEXT(a_decide_replies, state_ff == S_DECIDE, rsp_valid_ff, "no reply")
   `TCLD_ASSERT_ALWAYS(a_bright_limit, ({10'b0, bright_ff} <= BRIGHT_MAX), "brightness over limit")
   `TCLD_ASSERT_ALWAYS(a_blink_limit, ({4'b0, blink_ff} <= BLINK_MAX), "blink over limit")

endmodule
